FILE: hdl/xetd_pkg.sv
// -----------------------------------------------------------------------------
// xetd_pkg: shared types, codes and UTF-8 helpers
// Status codes, the job word handed from the parser to the encoder, and the
// functions that split a code point into UTF-8 bytes.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xetd_pkg;

   // result status codes
   localparam logic [2:0] ST_DATA      = 3'd0;
   localparam logic [2:0] ST_CLEAN     = 3'd1;
   localparam logic [2:0] ST_NUL       = 3'd2;
   localparam logic [2:0] ST_UNTERM    = 3'd3;
   localparam logic [2:0] ST_UNKNOWN   = 3'd4;
   localparam logic [2:0] ST_BADNUM    = 3'd5;
   localparam logic [2:0] ST_BADSCALAR = 3'd6;

   localparam int QUEUE_DEPTH = 4;

   // one unit of work for the encoder
   typedef struct packed {
      logic        raw;     // send code[7:0] as one byte, no encoding
      logic [20:0] code;    // code point or raw byte
      logic [2:0]  status;  // nonzero: end-of-run report
   } job_type;

   // number of UTF-8 bytes minus one
   function automatic logic [1:0] utf8_last(input logic [20:0] c);
      logic [1:0] n;
      if (c < 21'h80)          n = 2'd0;
      else if (c < 21'h800)    n = 2'd1;
      else if (c < 21'h10000)  n = 2'd2;
      else                     n = 2'd3;
      return n;
   endfunction

   // byte idx of the UTF-8 form of c, whose length minus one is last
   function automatic logic [7:0] utf8_byte(input logic [20:0] c, input logic [1:0] last,
                                            input logic [1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (last)
         2'd0: b = c[7:0];
         2'd1: b = (idx == 2'd0) ? {3'b110, c[10:6]} : {2'b10, c[5:0]};
         2'd2: begin
            case (idx)
               2'd0:    b = {4'b1110, c[15:12]};
               2'd1:    b = {2'b10, c[11:6]};
               default: b = {2'b10, c[5:0]};
            endcase
         end
         default: begin
            case (idx)
               2'd0:    b = {5'b11110, c[20:18]};
               2'd1:    b = {2'b10, c[17:12]};
               2'd2:    b = {2'b10, c[11:6]};
               default: b = {2'b10, c[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/xetd_front.sv
// -----------------------------------------------------------------------------
// xetd_front: entity parser
// Takes one text beat per cycle while accept is high, tracks entity and number state, and pushes
// one job per beat that yields output.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xetd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              operation,
   input  wire logic [7:0]        text_byte,
   output logic                   push,
   output xetd_pkg::job_type      push_job
);

   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_SEMI = 8'h3b;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_X    = 8'h78;

   typedef enum logic [3:0] {
      M_PLAIN  = 4'b0001,
      M_NAME   = 4'b0010,
      M_HASH   = 4'b0100,
      M_DIGITS = 4'b1000
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [31:0] name_ff, name_in;
   logic [2:0]  nlen_ff, nlen_in;
   logic        hex_ff, hex_in;
   logic        digit_ff, digit_in;
   logic [31:0] code_ff, code_in;
   logic        ovf_ff, ovf_in;
   logic        bad_ff, bad_in;
   logic [2:0]  err_ff, err_in;

   // digit decode and accumulate
   logic        dig_ok;
   logic [3:0]  dig_val;
   logic [35:0] acc;
   logic        name_hit;
   logic [7:0]  name_char;

   always_comb begin
      dig_ok  = 1'b1;
      dig_val = 4'd0;
      if (text_byte inside {[8'h30:8'h39]}) begin
         dig_val = 4'(text_byte - 8'h30);
      end else if (hex_ff && (text_byte inside {[8'h61:8'h66]})) begin
         dig_val = 4'(text_byte - 8'h57);
      end else if (hex_ff && (text_byte inside {[8'h41:8'h46]})) begin
         dig_val = 4'(text_byte - 8'h37);
      end else begin
         dig_ok = 1'b0;
      end
      if (hex_ff) begin
         acc = {code_ff, dig_val};
      end else begin
         acc = ({4'd0, code_ff} << 3) + ({4'd0, code_ff} << 1) + {32'd0, dig_val};
      end
   end

   always_comb begin
      name_hit  = 1'b1;
      name_char = 8'h00;
      if (nlen_ff == 3'd3 && name_ff == 32'h00616d70)      name_char = 8'h26;
      else if (nlen_ff == 3'd2 && name_ff == 32'h00006c74) name_char = 8'h3c;
      else if (nlen_ff == 3'd2 && name_ff == 32'h00006774) name_char = 8'h3e;
      else if (nlen_ff == 3'd4 && name_ff == 32'h71756f74) name_char = 8'h22;
      else if (nlen_ff == 3'd4 && name_ff == 32'h61706f73) name_char = 8'h27;
      else name_hit = 1'b0;
   end

   always_comb begin
      mode_in  = mode_ff;
      name_in  = name_ff;
      nlen_in  = nlen_ff;
      hex_in   = hex_ff;
      digit_in = digit_ff;
      code_in  = code_ff;
      ovf_in   = ovf_ff;
      bad_in   = bad_ff;
      err_in   = err_ff;
      push     = 1'b0;
      push_job = '0;
      if (accept) begin
         if (operation) begin
            // end of run: report and return to reset state
            push = 1'b1;
            if (err_ff != xetd_pkg::ST_DATA) begin
               push_job.status = err_ff;
            end else if (mode_ff != M_PLAIN) begin
               push_job.status = xetd_pkg::ST_UNTERM;
            end else begin
               push_job.status = xetd_pkg::ST_CLEAN;
            end
            mode_in  = M_PLAIN;
            name_in  = '0;
            nlen_in  = '0;
            hex_in   = 1'b0;
            digit_in = 1'b0;
            code_in  = '0;
            ovf_in   = 1'b0;
            bad_in   = 1'b0;
            err_in   = xetd_pkg::ST_DATA;
         end else if (err_ff == xetd_pkg::ST_DATA) begin
            if (mode_ff == M_PLAIN) begin
               if (text_byte == CH_AMP) begin
                  mode_in  = M_NAME;
                  name_in  = '0;
                  nlen_in  = '0;
                  hex_in   = 1'b0;
                  digit_in = 1'b0;
                  code_in  = '0;
                  ovf_in   = 1'b0;
                  bad_in   = 1'b0;
               end else if (text_byte == 8'h00) begin
                  err_in = xetd_pkg::ST_NUL;
               end else begin
                  push          = 1'b1;
                  push_job.raw  = 1'b1;
                  push_job.code = {13'd0, text_byte};
               end
            end else if (text_byte == CH_SEMI) begin
               if (mode_ff == M_NAME) begin
                  if (name_hit) begin
                     push          = 1'b1;
                     push_job.raw  = 1'b1;
                     push_job.code = {13'd0, name_char};
                  end else begin
                     err_in = xetd_pkg::ST_UNKNOWN;
                  end
               end else if (!digit_ff || bad_ff || ovf_ff) begin
                  err_in = xetd_pkg::ST_BADNUM;
               end else if (code_ff == 32'd0 || code_ff > 32'h0010ffff ||
                            (code_ff >= 32'h0000d800 && code_ff <= 32'h0000dfff)) begin
                  err_in = xetd_pkg::ST_BADSCALAR;
               end else begin
                  push          = 1'b1;
                  push_job.code = code_ff[20:0];
               end
               mode_in  = M_PLAIN;
               name_in  = '0;
               nlen_in  = '0;
               hex_in   = 1'b0;
               digit_in = 1'b0;
               code_in  = '0;
               ovf_in   = 1'b0;
               bad_in   = 1'b0;
            end else begin
               case (mode_ff)
                  M_NAME: begin
                     if (nlen_ff == 3'd0 && text_byte == CH_HASH) begin
                        mode_in = M_HASH;
                     end else begin
                        name_in = {name_ff[23:0], text_byte};
                        if (nlen_ff != 3'd7) nlen_in = nlen_ff + 3'd1;
                     end
                  end
                  M_HASH, M_DIGITS: begin
                     mode_in = M_DIGITS;
                     if (mode_ff == M_HASH && text_byte == CH_X) begin
                        hex_in = 1'b1;
                     end else if (dig_ok) begin
                        code_in  = acc[31:0];
                        digit_in = 1'b1;
                        if (acc[35:32] != 4'd0) ovf_in = 1'b1;
                     end else begin
                        bad_in = 1'b1;
                     end
                  end
                  default: begin
                     mode_in = mode_ff;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_PLAIN;
         name_ff  <= '0;
         nlen_ff  <= '0;
         hex_ff   <= 1'b0;
         digit_ff <= 1'b0;
         code_ff  <= '0;
         ovf_ff   <= 1'b0;
         bad_ff   <= 1'b0;
         err_ff   <= xetd_pkg::ST_DATA;
      end else begin
         mode_ff  <= mode_in;
         name_ff  <= name_in;
         nlen_ff  <= nlen_in;
         hex_ff   <= hex_in;
         digit_ff <= digit_in;
         code_ff  <= code_in;
         ovf_ff   <= ovf_in;
         bad_ff   <= bad_in;
         err_ff   <= err_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/xetd_queue.sv
// -----------------------------------------------------------------------------
// xetd_queue: job queue
// Small first-in first-out store of jobs between parser and encoder.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xetd_queue #(
   parameter int DEPTH = xetd_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire xetd_pkg::job_type push_job,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output xetd_pkg::job_type      head_job
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   xetd_pkg::job_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_pop;

   assign full       = (cnt_ff == CW'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = slot_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/xetd_back.sv
// -----------------------------------------------------------------------------
// xetd_back: UTF-8 encoder
// Walks the head job one output byte per cycle into the result register while not stalled.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xetd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire xetd_pkg::job_type head_job,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic [2:0]             rsp_status,
   output logic                   rsp_last_of_run
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [2:0] status_ff, status_in;
   logic       last_ff, last_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic [1:0] nlast;

   assign load  = !valid_ff || !rsp_stall;
   assign nlast = (head_job.raw || head_job.status != xetd_pkg::ST_DATA) ? 2'd0
                  : xetd_pkg::utf8_last(head_job.code);

   always_comb begin
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      status_in = status_ff;
      last_in   = last_ff;
      idx_in    = idx_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            status_in = head_job.status;
            last_in   = (idx_ff == nlast);
            if (head_job.status != xetd_pkg::ST_DATA) begin
               byte_in = 8'h00;
            end else begin
               byte_in = xetd_pkg::utf8_byte(head_job.code, nlast, idx_ff);
            end
            if (idx_ff == nlast) begin
               pop    = 1'b1;
               idx_in = 2'd0;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_status      = status_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

FILE: hdl/xml_entity_text_decoder.sv
// A beat that yields output passes through the job queue and the result register.
// Throughput: one input beat per cycle while the job queue has room; the encoder
//   sends one output byte per cycle while not stalled; a numeric entity takes 1 to 4 bytes.
// Reset: synchronous, active high; parser returns to plain text with no error,
//   queue and output register are emptied. No clearing pass.
// -----------------------------------------------------------------------------
// xml_entity_text_decoder: XML text-run entity decoder with UTF-8 output
// Parser front end feeds a job queue; an encoder back end drains it into the
// result register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xml_entity_text_decoder #(
   parameter int QUEUE_DEPTH = xetd_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request beats: one text byte or an end-of-run marker
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_text_byte,
   // response beats: decoded bytes or end-of-run status
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic [2:0]       rsp_status,
   output logic             rsp_last_of_run
);

   logic              accept;
   logic              q_push;
   xetd_pkg::job_type q_push_job;
   logic              q_full;
   logic              q_pop;
   logic              q_head_valid;
   xetd_pkg::job_type q_head_job;

   // The front end only waits on queue space; the output side never reaches it
   // directly, so a stalled result blocks parsing only once the queue fills.
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // Parser: every beat is classified in the cycle it is accepted. Plain bytes,
   // named entities, closed numbers and end-of-run markers become one job each;
   // errors only update the sticky error state.
   xetd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_operation),
      .text_byte (req_text_byte),
      .push      (q_push),
      .push_job  (q_push_job)
   );

   // Job queue holds up to QUEUE_DEPTH jobs; the encoder expands each code point to up to four bytes.
   xetd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_job   (q_head_job)
   );

   // Encoder: one response beat per cycle while rsp_stall is low, popping a job on its last byte.
   xetd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head_job        (q_head_job),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

`ifndef SYNTHESIS
   // a status beat is always a single, closing beat carrying a zero byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != xetd_pkg::ST_DATA) |->
         (rsp_last_of_run && rsp_out_byte == 8'h00))
      else $error("status beat not closing");

   // the parser never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("push into full job queue");

   // nothing is presented right after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule

`default_nettype wire
